// ===== src/ook_remote_code_transmitter_assert.svh =====
// Assertion macros shared by the transmitter checker.
`ifndef OOK_REMOTE_CODE_TRANSMITTER_ASSERT_SVH
`define OOK_REMOTE_CODE_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OOKT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OOKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ookt_pkg.sv =====
// Shared types and constants of the OOK remote code transmitter.
`timescale 1ns / 1ps

package ookt_pkg;

  localparam int CODE_WIDTH_DEF = 32;
  localparam int UNIT_WIDTH_DEF = 12;

  localparam int CODE_IN_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int UNITS_W = 6;

  localparam logic [5:0]  CODE_BITS_RST = 6'd24;
  localparam logic [7:0]  REPEAT_COUNT_RST = 8'd5;
  localparam logic [11:0] PULSE_MIN_RST = 12'd176;
  localparam logic [11:0] PULSE_MAX_RST = 12'd186;

  localparam logic [UNITS_W-1:0] UNITS_SYNC_HIGH = 6'd1;
  localparam logic [UNITS_W-1:0] UNITS_SYNC_LOW = 6'd31;
  localparam logic [UNITS_W-1:0] UNITS_GAP = 6'd32;
  localparam logic [UNITS_W-1:0] UNITS_LONG = 6'd3;
  localparam logic [UNITS_W-1:0] UNITS_SHORT = 6'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CODE_BITS    = 2'd0,
    REG_REPEAT_COUNT = 2'd1,
    REG_PULSE_MIN    = 2'd2,
    REG_PULSE_MAX    = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_SYNC_HIGH = 6'b000010,
    PH_SYNC_LOW  = 6'b000100,
    PH_BIT_HIGH  = 6'b001000,
    PH_BIT_LOW   = 6'b010000,
    PH_GAP       = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [5:0]  code_bits;
    logic [7:0]  repeat_count;
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
  } cfg_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic done;
  } res_t;

endpackage

// ===== src/ookt_cfg.sv =====
// Configuration register file of the OOK remote code transmitter.
`timescale 1ns / 1ps

module ookt_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ookt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ookt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ookt_pkg::cfg_t                     cfg
);

  ookt_pkg::cfg_t cfg_r;
  ookt_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (ookt_pkg::reg_idx_t'(cfg_addr))
        ookt_pkg::REG_CODE_BITS:    cfg_nxt.code_bits = cfg_data[5:0];
        ookt_pkg::REG_REPEAT_COUNT: cfg_nxt.repeat_count = cfg_data[7:0];
        ookt_pkg::REG_PULSE_MIN:    cfg_nxt.pulse_min = cfg_data[11:0];
        ookt_pkg::REG_PULSE_MAX:    cfg_nxt.pulse_max = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_bits <= ookt_pkg::CODE_BITS_RST;
      cfg_r.repeat_count <= ookt_pkg::REPEAT_COUNT_RST;
      cfg_r.pulse_min <= ookt_pkg::PULSE_MIN_RST;
      cfg_r.pulse_max <= ookt_pkg::PULSE_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/ookt_core.sv =====
// Pulse sequencer: segment state and the result of each accepted item.
`timescale 1ns / 1ps

module ookt_core #(
  parameter int CODE_WIDTH = ookt_pkg::CODE_WIDTH_DEF,
  parameter int UNIT_WIDTH = ookt_pkg::UNIT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic                              kind,
  input  logic [ookt_pkg::CODE_IN_W-1:0]    code,
  input  ookt_pkg::cfg_t                    cfg,
  output ookt_pkg::res_t                    res
);

  localparam int BPW = $clog2(CODE_WIDTH + 1);
  localparam int IW = (CODE_WIDTH > 1) ? $clog2(CODE_WIDTH) : 1;
  localparam int UW = UNIT_WIDTH;

  ookt_pkg::phase_t               phase_r, phase_nxt;
  logic [UW-1:0]                  cur_r, cur_nxt;
  logic [7:0]                     burst_r, burst_nxt;
  logic [BPW-1:0]                 bitpos_r, bitpos_nxt;
  logic [UW-1:0]                  tick_r, tick_nxt;
  logic [ookt_pkg::UNITS_W-1:0]   units_r, units_nxt;
  logic [CODE_WIDTH-1:0]          held_r, held_nxt;
  logic                           level_r, level_nxt;

  logic [63:0]                    code_ext;
  logic [15:0]                    pmin16, pmax16;
  logic [UW-1:0]                  pmin_u, pmax_u, eff_min;
  logic [BPW-1:0]                 eff_bits;
  logic [UW:0]                    tick_inc;
  logic [ookt_pkg::UNITS_W-1:0]   ul_dec;
  logic                           cur_bit, first_bit, next_bit;
  logic                           line, done;

  assign code_ext = {32'd0, code};
  assign pmin16 = 16'(cfg.pulse_min);
  assign pmax16 = 16'(cfg.pulse_max);
  assign pmin_u = pmin16[UW-1:0];
  assign pmax_u = pmax16[UW-1:0];
  assign eff_min = (pmin_u == '0) ? UW'(1) : pmin_u;
  assign eff_bits = ({1'b0, cfg.code_bits} > 7'(CODE_WIDTH)) ? BPW'(CODE_WIDTH)
                                                               : BPW'(cfg.code_bits);
  assign tick_inc = {1'b0, tick_r} + 1'b1;
  assign ul_dec = (units_r == '0) ? '0 : units_r - 1'b1;
  assign cur_bit = held_r[IW'(bitpos_r - 1'b1)];
  assign next_bit = held_r[IW'(bitpos_r - BPW'(2))];
  assign first_bit = held_r[IW'(eff_bits - 1'b1)];

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt = cur_r;
    burst_nxt = burst_r;
    bitpos_nxt = bitpos_r;
    tick_nxt = tick_r;
    units_nxt = units_r;
    held_nxt = held_r;
    level_nxt = level_r;
    line = 1'b0;
    done = 1'b0;
    if (!kind) begin
      if (phase_r == ookt_pkg::PH_IDLE) begin
        if (eff_min > pmax_u) begin
          done = 1'b1;
        end else begin
          held_nxt = code_ext[CODE_WIDTH-1:0];
          cur_nxt = eff_min;
          burst_nxt = cfg.repeat_count;
          bitpos_nxt = '0;
          phase_nxt = ookt_pkg::PH_SYNC_HIGH;
          units_nxt = ookt_pkg::UNITS_SYNC_HIGH;
          tick_nxt = '0;
        end
      end
      line = level_r;
    end else if (phase_r == ookt_pkg::PH_IDLE) begin
      level_nxt = 1'b0;
    end else begin
      line = (phase_r == ookt_pkg::PH_SYNC_HIGH) || (phase_r == ookt_pkg::PH_BIT_HIGH);
      level_nxt = line;
      if (tick_inc >= {1'b0, cur_r}) begin
        tick_nxt = '0;
        units_nxt = ul_dec;
        if (ul_dec == '0) begin
          case (phase_r)
            ookt_pkg::PH_SYNC_HIGH: begin
              phase_nxt = ookt_pkg::PH_SYNC_LOW;
              units_nxt = ookt_pkg::UNITS_SYNC_LOW;
            end
            ookt_pkg::PH_SYNC_LOW: begin
              if (burst_r == '0) begin
                phase_nxt = ookt_pkg::PH_GAP;
                units_nxt = ookt_pkg::UNITS_GAP;
              end else begin
                burst_nxt = burst_r - 1'b1;
                bitpos_nxt = eff_bits;
                if (eff_bits == '0) begin
                  phase_nxt = ookt_pkg::PH_SYNC_HIGH;
                  units_nxt = ookt_pkg::UNITS_SYNC_HIGH;
                end else begin
                  phase_nxt = ookt_pkg::PH_BIT_HIGH;
                  units_nxt = first_bit ? ookt_pkg::UNITS_LONG : ookt_pkg::UNITS_SHORT;
                end
              end
            end
            ookt_pkg::PH_BIT_HIGH: begin
              phase_nxt = ookt_pkg::PH_BIT_LOW;
              units_nxt = cur_bit ? ookt_pkg::UNITS_SHORT : ookt_pkg::UNITS_LONG;
            end
            ookt_pkg::PH_BIT_LOW: begin
              bitpos_nxt = bitpos_r - 1'b1;
              if (bitpos_r == BPW'(1)) begin
                phase_nxt = ookt_pkg::PH_SYNC_HIGH;
                units_nxt = ookt_pkg::UNITS_SYNC_HIGH;
              end else begin
                phase_nxt = ookt_pkg::PH_BIT_HIGH;
                units_nxt = next_bit ? ookt_pkg::UNITS_LONG : ookt_pkg::UNITS_SHORT;
              end
            end
            default: begin
              if (cur_r >= pmax_u) begin
                phase_nxt = ookt_pkg::PH_IDLE;
                units_nxt = '0;
                cur_nxt = '0;
                done = 1'b1;
                level_nxt = 1'b0;
              end else begin
                cur_nxt = cur_r + 1'b1;
                burst_nxt = cfg.repeat_count;
                phase_nxt = ookt_pkg::PH_SYNC_HIGH;
                units_nxt = ookt_pkg::UNITS_SYNC_HIGH;
              end
            end
          endcase
        end
      end else begin
        tick_nxt = tick_inc[UW-1:0];
      end
    end
    res.line = line;
    res.busy = (phase_nxt != ookt_pkg::PH_IDLE);
    res.done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ookt_pkg::PH_IDLE;
      cur_r <= '0;
      burst_r <= '0;
      bitpos_r <= '0;
      tick_r <= '0;
      units_r <= '0;
      held_r <= '0;
      level_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cur_r <= cur_nxt;
      burst_r <= burst_nxt;
      bitpos_r <= bitpos_nxt;
      tick_r <= tick_nxt;
      units_r <= units_nxt;
      held_r <= held_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ===== src/ookt_out.sv =====
// Result register between the sequencer and the output stream.
`timescale 1ns / 1ps

module ookt_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            acc,
  input  ookt_pkg::res_t  res,
  output logic            out_tvalid,
  input  logic            out_tready,
  output ookt_pkg::res_t  res_out
);

  logic           out_valid_r, out_valid_nxt;
  ookt_pkg::res_t res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign out_valid_nxt = acc || (out_valid_r && !out_tready);
  assign out_tvalid = out_valid_r;
  assign res_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

endmodule

// ===== src/ook_remote_code_transmitter.sv =====
// Top level of the OOK remote code transmitter.
// A result appears in the cycle after its input transfer.
// Throughput: one item per cycle; input ready drops only while a result waits and out_tready is low.
// Each tick item updates the segment counters once; the result register decouples the sides.
// Reset (synchronous, rst_n low) returns the sequencer to idle with the line low
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module ook_remote_code_transmitter #(
  parameter int CODE_WIDTH = ookt_pkg::CODE_WIDTH_DEF,
  parameter int UNIT_WIDTH = ookt_pkg::UNIT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ookt_pkg::CODE_IN_W-1:0]   in_tdata,   // [31:0] code
  input  logic                             in_tuser,   // [0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] line, [1] busy_res, [7:2] zero
  output logic                             out_tlast,  // done_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ookt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ookt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ookt_pkg::cfg_t cfg;
  ookt_pkg::res_t res;
  ookt_pkg::res_t res_out;
  logic           acc;

  ookt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ookt_core #(
    .CODE_WIDTH (CODE_WIDTH),
    .UNIT_WIDTH (UNIT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .kind  (in_tuser),
    .code  (in_tdata),
    .cfg   (cfg),
    .res   (res)
  );

  ookt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .acc        (acc),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_out    (res_out)
  );

  assign out_tdata = {6'd0, res_out.busy, res_out.line};
  assign out_tlast = res_out.done;

endmodule

// ===== src/ookt_checker.sv =====
// Port-level checker of the transmitter and its bind to the top level.
`timescale 1ns / 1ps
`include "ook_remote_code_transmitter_assert.svh"

module ookt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        cfg_ready
);

  `OOKT_ASSERT_SAME(a_done_not_busy, out_tvalid && out_tlast, !out_tdata[1],
    "sweep end reported while still busy")
  `OOKT_ASSERT_SAME(a_high_needs_busy, out_tvalid && out_tdata[0], out_tdata[1],
    "line high outside a sequence")
  `OOKT_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready && cfg_ready,
    "input stalled with no result waiting")
  `OOKT_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[7:2] == 6'd0,
    "padding bits of the result not zero")
  `OOKT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast),
    "stalled result changed")

endmodule

bind ook_remote_code_transmitter ookt_checker u_ookt_checker (.*);
